@@ rtl/fbvt_pkg.sv @@
// Shared types, constants and plane helpers for the frustum box visibility test.
package fbvt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FIELD_W     = 32;
	localparam int ENTRY_W     = 32;
	localparam int COEF_W      = ENTRY_W + 1;
	localparam int PROD_W      = COEF_W + FIELD_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int FRAC_W      = 16;
	localparam int N_REGS      = 8;
	localparam int REG_IDX_W   = $clog2(N_REGS);
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int N_PLANES    = 6;
	localparam int N_ROWS      = 4;
	localparam int N_AXES      = 3;
	localparam int FIFO_DEPTH  = 32;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef logic signed [FIELD_W-1:0] coord_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic [N_REGS-1:0][CFG_DATA_W-1:0] mat_t;

	typedef enum logic [2:0] {
		PL_LEFT   = 3'd0,
		PL_RIGHT  = 3'd1,
		PL_TOP    = 3'd2,
		PL_BOTTOM = 3'd3,
		PL_NEAR   = 3'd4,
		PL_FAR    = 3'd5
	} plane_t;

	// Box with each axis already ordered into its smaller and larger coordinate.
	typedef struct packed {
		logic [N_AXES-1:0][FIELD_W-1:0] lo;
		logic [N_AXES-1:0][FIELD_W-1:0] hi;
	} box_t;

	typedef struct packed {
		logic valid;
		logic vis;
		box_t box;
	} tok_t;

	// Identity matrix in Q16.16, registers ordered row1_lo at index 0 up to row4_hi.
	localparam mat_t MAT_RESET = {
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
	};

	function automatic coord_t coord_norm(logic [FIELD_W-1:0] v);
		return coord_t'($signed(v << (FIELD_W - COORD_WIDTH)) >>> (FIELD_W - COORD_WIDTH));
	endfunction

	function automatic entry_t mentry(mat_t m, logic [1:0] row, logic [1:0] col);
		logic [CFG_DATA_W-1:0] word;
		word = m[{row, col[1]}];
		return col[0] ? entry_t'(word[CFG_DATA_W-1:ENTRY_W]) : entry_t'(word[ENTRY_W-1:0]);
	endfunction

	function automatic coef_t plane_coef(mat_t m, plane_t p, logic [1:0] row);
		coef_t w;
		coef_t e0;
		coef_t e1;
		coef_t e2;
		coef_t res;
		w  = coef_t'(mentry(m, row, 2'd3));
		e0 = coef_t'(mentry(m, row, 2'd0));
		e1 = coef_t'(mentry(m, row, 2'd1));
		e2 = coef_t'(mentry(m, row, 2'd2));
		case (p)
			PL_LEFT:   res = w + e0;
			PL_RIGHT:  res = w - e0;
			PL_TOP:    res = w - e1;
			PL_BOTTOM: res = w + e1;
			PL_NEAR:   res = e2;
			default:   res = w - e2;
		endcase
		return res;
	endfunction

endpackage

@@ rtl/fbvt_if.sv @@
// Channel interfaces: box input, visibility result and configuration writes.
interface fbvt_box_if import fbvt_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t min_x;
	coord_t min_y;
	coord_t min_z;
	coord_t max_x;
	coord_t max_y;
	coord_t max_z;
	modport source (output valid, output min_x, output min_y, output min_z,
		output max_x, output max_y, output max_z, input ready);
	modport sink (input valid, input min_x, input min_y, input min_z,
		input max_x, input max_y, input max_z, output ready);
endinterface

interface fbvt_vis_if ();
	logic valid;
	logic ready;
	logic visible;
	modport source (output valid, output visible, input ready);
	modport sink (input valid, input visible, output ready);
endinterface

interface fbvt_cfg_if import fbvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/fbvt_plane_cell.sv @@
// One plane cell: evaluates the most positive box corner against its plane in three stages.
module fbvt_plane_cell import fbvt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  plane_t plane,
	input  mat_t   mat,
	input  tok_t   tok_in,
	output tok_t   tok_out
);

	coef_t                    coef_q [N_ROWS];
	coord_t                   sel [N_AXES];
	logic signed [PROD_W-1:0] prod_s1 [N_AXES];
	logic signed [PROD_W-1:0] dterm_s1;
	logic signed [SUM_W-1:0]  sum_a_s2;
	logic signed [SUM_W-1:0]  sum_b_s2;
	logic signed [SUM_W-1:0]  total;
	logic                     vld_s1, vld_s2, vld_s3;
	logic                     vis_s1, vis_s2, vis_s3;
	box_t                     box_s1, box_s2, box_s3;

	always_ff @(posedge clk) begin
		for (int r = 0; r < N_ROWS; r++) begin
			coef_q[r] <= plane_coef(mat, plane, 2'(r));
		end
	end

	// A non-negative coefficient picks the larger coordinate of its axis.
	always_comb begin
		for (int k = 0; k < N_AXES; k++) begin
			sel[k] = coef_q[k][COEF_W-1] ? coord_t'(tok_in.box.lo[k])
			                             : coord_t'(tok_in.box.hi[k]);
		end
	end

	assign total = sum_a_s2 + sum_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= tok_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_AXES; k++) begin
			prod_s1[k] <= coef_q[k] * sel[k];
		end
		dterm_s1 <= PROD_W'(coef_q[N_ROWS-1]) <<< FRAC_W;
		vis_s1   <= tok_in.vis;
		box_s1   <= tok_in.box;

		sum_a_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]);
		sum_b_s2 <= SUM_W'(prod_s1[2]) + SUM_W'(dterm_s1);
		vis_s2   <= vis_s1;
		box_s2   <= box_s1;

		vis_s3   <= vis_s2 & (total > 0);
		box_s3   <= box_s2;
	end

	assign tok_out.valid = vld_s3;
	assign tok_out.vis   = vis_s3;
	assign tok_out.box   = box_s3;

endmodule

@@ rtl/fbvt_out_fifo.sv @@
// Result queue that decouples the never-stalling cell chain from the result receiver.
module fbvt_out_fifo import fbvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_vis,
	input  logic pop,
	output logic not_empty,
	output logic head_vis
);

	logic               mem_q [FIFO_DEPTH];
	logic [FIFO_AW:0]   wr_ptr_q;
	logic [FIFO_AW:0]   rd_ptr_q;
	logic               head_vld_q;
	logic               head_q;
	logic               mem_empty;
	logic               head_free;
	logic               bypass;
	logic               fetch;

	// The head register is refilled from the array, or straight from the input when the
	// array is empty, so a lone result is offered in the cycle after it is pushed.
	assign mem_empty = (wr_ptr_q == rd_ptr_q);
	assign head_free = !head_vld_q || pop;
	assign bypass    = push && mem_empty && head_free;
	assign fetch     = !mem_empty && head_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (push && !bypass) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (fetch) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (head_free) begin
				head_vld_q <= bypass || fetch;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !bypass) begin
			mem_q[wr_ptr_q[FIFO_AW-1:0]] <= push_vis;
		end
		if (fetch) begin
			head_q <= mem_q[rd_ptr_q[FIFO_AW-1:0]];
		end else if (bypass) begin
			head_q <= push_vis;
		end
	end

	assign not_empty = head_vld_q;
	assign head_vis  = head_q;

endmodule

@@ rtl/frustum_box_visibility_test_top.sv @@
// Frustum box visibility test: culls axis-aligned boxes against six view-projection planes.
//
// Channels: box carries one axis-aligned box (min and max corner, Q16.16) per transaction,
// res returns one visible bit per box in the same order, and cfg writes the eight 64-bit
// matrix registers (index 0 is row1_lo up to index 7 is row4_hi; higher indices are ignored).
// cfg is always ready and must only be used while no box is outstanding.
// Throughput is one box per clock while box.ready is high. A box accepted at a clock edge
// reaches res through the coordinate ordering register, which loads at the accepting edge,
// then through the six plane cells (multiply, partial sums, final sum and sign in each)
// and the head register of the result queue.
// The plane cells never stall. A 32-entry result queue absorbs results while res is held
// off, and box.ready drops only once 32 boxes are accepted but not yet delivered, so input
// keeps flowing during short stalls of the receiver.
// Reset loads the identity matrix and empties the pipeline and the queue; no clearing pass.
module frustum_box_visibility_test_top import fbvt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	fbvt_box_if.sink   box,
	fbvt_vis_if.source res,
	fbvt_cfg_if.sink   cfg
);

	mat_t              mat_q;
	logic [FIFO_AW:0]  occ_q;
	logic              acc;
	logic              pop;
	logic              tok0_vld_q;
	box_t              tok0_box_q;
	coord_t            in_min [N_AXES];
	coord_t            in_max [N_AXES];
	tok_t              chain [N_PLANES+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= MAT_RESET;
		end else if (cfg.valid && (cfg.index < CFG_IDX_W'(N_REGS))) begin
			mat_q[cfg.index[REG_IDX_W-1:0]] <= cfg.data;
		end
	end

	// Credit count of boxes accepted but not yet delivered; bounded by the queue depth.
	assign box.ready = (occ_q < (FIFO_AW+1)'(FIFO_DEPTH));
	assign acc       = box.valid && box.ready;
	assign pop       = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({acc, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	assign in_min[0] = coord_norm(box.min_x);
	assign in_min[1] = coord_norm(box.min_y);
	assign in_min[2] = coord_norm(box.min_z);
	assign in_max[0] = coord_norm(box.max_x);
	assign in_max[1] = coord_norm(box.max_y);
	assign in_max[2] = coord_norm(box.max_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_vld_q <= 1'b0;
		end else begin
			tok0_vld_q <= acc;
		end
	end

	// The corners are all combinations of the given values, so each axis is simply ordered.
	always_ff @(posedge clk) begin
		for (int k = 0; k < N_AXES; k++) begin
			if (in_min[k] < in_max[k]) begin
				tok0_box_q.lo[k] <= in_min[k];
				tok0_box_q.hi[k] <= in_max[k];
			end else begin
				tok0_box_q.lo[k] <= in_max[k];
				tok0_box_q.hi[k] <= in_min[k];
			end
		end
	end

	assign chain[0].valid = tok0_vld_q;
	assign chain[0].vis   = 1'b1;
	assign chain[0].box   = tok0_box_q;

	for (genvar p = 0; p < N_PLANES; p++) begin : g_cell
		fbvt_plane_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.plane   (plane_t'(p)),
			.mat     (mat_q),
			.tok_in  (chain[p]),
			.tok_out (chain[p+1])
		);
	end

	fbvt_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (chain[N_PLANES].valid),
		.push_vis  (chain[N_PLANES].vis),
		.pop       (pop),
		.not_empty (res.valid),
		.head_vis  (res.visible)
	);

endmodule

@@ rtl/fbvt_checker.sv @@
// Port-level checks of the result handshake and credit behaviour, bound to the top level.
module fbvt_checker import fbvt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic box_valid,
	input logic box_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_visible
);

	logic [FIFO_AW+1:0] outstanding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + (FIFO_AW+2)'(box_valid && box_ready)
				- (FIFO_AW+2)'(res_valid && res_ready);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result transaction withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_visible))
		else $error("result payload changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q == '0) |-> !res_valid)
		else $error("result offered with no box outstanding");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q >= (FIFO_AW+2)'(FIFO_DEPTH)) |-> !box_ready)
		else $error("box accepted beyond result queue capacity");

endmodule

bind frustum_box_visibility_test_top fbvt_checker u_fbvt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.box_valid   (box.valid),
	.box_ready   (box.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_visible (res.visible)
);

@@ sim/tb_frustum_box_visibility_test_top.sv @@
// Self-checking testbench for the frustum box visibility test, with a bit-exact plane predictor.
`timescale 1ns / 1ps

module tb_frustum_box_visibility_test_top import fbvt_pkg::*; ();

	localparam coord_t      ONE            = 32'sh0001_0000;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned END_CYCLES     = 40;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	typedef enum int {
		REG_ROW1_LO, REG_ROW1_HI, REG_ROW2_LO, REG_ROW2_HI,
		REG_ROW3_LO, REG_ROW3_HI, REG_ROW4_LO, REG_ROW4_HI
	} reg_index_t;

	typedef enum int {MAT_SMALL, MAT_EXTREME, MAT_ZERO, MAT_ONES, MAT_DONLY, MAT_RANDOM} mat_kind_t;
	typedef enum int {RX_OPEN, RX_PERIODIC, RX_COIN, RX_SPARSE} rx_mode_t;

	typedef struct {
		coord_t corner_min [N_AXES];
		coord_t corner_max [N_AXES];
	} box_item_t;

	logic clk;
	logic arst_n;

	fbvt_box_if box ();
	fbvt_vis_if res ();
	fbvt_cfg_if cfg ();

	frustum_box_visibility_test_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	logic [CFG_DATA_W-1:0] vp_regs [N_REGS];
	box_item_t             box_pending [$];
	logic                  vis_expected [$];
	int unsigned           mismatches = 0;
	bit                    hold_req = 1'b0;

	// Visibility from the exact Q48.32 plane value at the most positive corner of each plane.
	function automatic logic predict_visible(box_item_t b);
		logic signed [ENTRY_W:0] ent [N_ROWS][4];
		logic signed [ENTRY_W:0] k [N_ROWS];
		logic signed [79:0]      acc;
		logic signed [79:0]      ca;
		logic signed [79:0]      cx;
		coord_t                  lo_c [N_AXES];
		coord_t                  hi_c [N_AXES];
		logic                    seen;
		seen = 1'b1;
		for (int r = 0; r < N_ROWS; r++)
			for (int c = 0; c < 4; c++)
				ent[r][c] = $signed(vp_regs[2*r + c/2][32*(c%2) +: 32]);
		for (int ax = 0; ax < N_AXES; ax++) begin
			lo_c[ax] = (b.corner_min[ax] < b.corner_max[ax]) ? b.corner_min[ax] : b.corner_max[ax];
			hi_c[ax] = (b.corner_min[ax] < b.corner_max[ax]) ? b.corner_max[ax] : b.corner_min[ax];
		end
		for (int p = PL_LEFT; p <= PL_FAR; p++) begin
			for (int r = 0; r < N_ROWS; r++) begin
				case (plane_t'(p))
					PL_LEFT:   k[r] = ent[r][3] + ent[r][0];
					PL_RIGHT:  k[r] = ent[r][3] - ent[r][0];
					PL_TOP:    k[r] = ent[r][3] - ent[r][1];
					PL_BOTTOM: k[r] = ent[r][3] + ent[r][1];
					PL_NEAR:   k[r] = ent[r][2];
					default:   k[r] = ent[r][3] - ent[r][2];
				endcase
			end
			acc = k[3];
			acc = acc <<< FRAC_W;
			for (int ax = 0; ax < N_AXES; ax++) begin
				ca = k[ax];
				cx = (k[ax] >= 0) ? hi_c[ax] : lo_c[ax];
				acc = acc + ca * cx;
			end
			if (acc <= 0)
				seen = 1'b0;
		end
		return seen;
	endfunction

	function automatic coord_t small_q(int unsigned half);
		return coord_t'($urandom_range(0, 2*half)) - coord_t'(half);
	endfunction

	function automatic box_item_t mk_box(coord_t x0, coord_t y0, coord_t z0,
		coord_t x1, coord_t y1, coord_t z1);
		box_item_t b;
		b.corner_min[0] = x0;
		b.corner_min[1] = y0;
		b.corner_min[2] = z0;
		b.corner_max[0] = x1;
		b.corner_max[1] = y1;
		b.corner_max[2] = z1;
		return b;
	endfunction

	// Boxes near the unit frustum for small_pct percent of calls, else full-range or corner-case values.
	function automatic box_item_t random_box(int unsigned small_pct);
		box_item_t   b;
		coord_t      a;
		coord_t      s;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		for (int ax = 0; ax < N_AXES; ax++) begin
			if (pick < small_pct) begin
				a = small_q(4 * ONE);
				s = coord_t'($urandom_range(0, 2 * ONE));
				if ($urandom_range(0, 7) == 0) begin
					b.corner_min[ax] = a + s;
					b.corner_max[ax] = a;
				end else begin
					b.corner_min[ax] = a;
					b.corner_max[ax] = a + s;
				end
			end else if (pick[0]) begin
				b.corner_min[ax] = $urandom;
				b.corner_max[ax] = $urandom;
			end else begin
				for (int j = 0; j < 2; j++) begin
					case ($urandom_range(0, 7))
						0: a = 32'sh8000_0000;
						1: a = 32'sh7FFF_FFFF;
						2: a = 0;
						3: a = 1;
						4: a = -1;
						5: a = ONE;
						6: a = -ONE;
						default: a = $urandom;
					endcase
					if (j == 0)
						b.corner_min[ax] = a;
					else
						b.corner_max[ax] = a;
				end
			end
		end
		return b;
	endfunction

	task automatic report_mismatch(string what, logic want, logic got);
		mismatches++;
		$display("MISMATCH at %0t: %s, expected %b, got %b", $time, what, want, got);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (cfg.ready !== 1'b1);
		if (idx < N_REGS)
			vp_regs[idx] = value;
	endtask

	task automatic program_matrix(mat_kind_t kind);
		logic [CFG_DATA_W-1:0] regs [N_REGS];
		coord_t                e [4];
		for (int r = 0; r < N_ROWS; r++) begin
			for (int c = 0; c < 4; c++) begin
				case (kind)
					MAT_SMALL:  e[c] = small_q(2 * ONE);
					MAT_ZERO:   e[c] = 0;
					MAT_ONES:   e[c] = -1;
					MAT_RANDOM: e[c] = $urandom;
					MAT_EXTREME: begin
						case ($urandom_range(0, 4))
							0: e[c] = 32'sh7FFF_FFFF;
							1: e[c] = 32'sh8000_0000;
							2: e[c] = 0;
							3: e[c] = ONE;
							default: e[c] = -ONE;
						endcase
					end
					default: begin
						// Only row 4 set: every plane reduces to its constant term, all positive.
						if (r < N_ROWS - 1)
							e[c] = 0;
						else if (c < 2)
							e[c] = small_q(ONE >>> 1);
						else if (c == 2)
							e[c] = ONE >>> 1;
						else
							e[c] = 2 * ONE;
					end
				endcase
			end
			regs[2*r]     = {e[1], e[0]};
			regs[2*r + 1] = {e[3], e[2]};
		end
		write_reg(CFG_IDX_W'($urandom_range(N_REGS, 2**CFG_IDX_W - 1)), {$urandom, $urandom});
		for (int i = REG_ROW1_LO; i <= REG_ROW4_HI; i++)
			write_reg(CFG_IDX_W'(i), regs[i]);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (box_pending.size() != 0 || vis_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(mat_kind_t kind, int unsigned n, int unsigned small_pct, bit with_hold);
		program_matrix(kind);
		if (with_hold)
			hold_req = 1'b1;
		repeat (n)
			box_pending.push_back(random_box(small_pct));
		wait_drained();
	endtask

	// Sender: bursts of random length; each short burst follows a random gap, long ones follow none.
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	bit          box_on     = 1'b0;
	bit          box_hs     = 1'b0;

	always @(posedge clk) begin
		box_item_t seen_box;
		box_hs = 1'b0;
		if (arst_n === 1'b1 && box.valid && box.ready) begin
			seen_box = mk_box(box.min_x, box.min_y, box.min_z, box.max_x, box.max_y, box.max_z);
			vis_expected.push_back(predict_visible(seen_box));
			void'(box_pending.pop_front());
			box_hs = 1'b1;
		end
	end

	always @(negedge clk) begin
		logic nv;
		nv = box_on;
		if (arst_n !== 1'b1) begin
			nv = 1'b0;
		end else if (!box_on || box_hs) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					burst_left = $urandom_range(100, 300);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left   = $urandom_range(1, 10);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				nv = 1'b0;
			end else if (box_pending.size() > 0) begin
				box.min_x <= box_pending[0].corner_min[0];
				box.min_y <= box_pending[0].corner_min[1];
				box.min_z <= box_pending[0].corner_min[2];
				box.max_x <= box_pending[0].corner_max[0];
				box.max_y <= box_pending[0].corner_max[1];
				box.max_z <= box_pending[0].corner_max[2];
				burst_left--;
				nv = 1'b1;
			end else begin
				nv = 1'b0;
			end
		end
		box_on = nv;
		box.valid <= nv;
	end

	// Receiver: its stall pattern is periodically redrawn at random; a hold request stops it for a long stretch.
	int unsigned hold_left = 0;
	int unsigned rx_cycle  = 0;
	rx_mode_t    rx_mode   = RX_OPEN;

	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n === 1'b1) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			rx_cycle++;
			if (rx_cycle % 50 == 0)
				rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
			if (hold_left > 0) begin
				hold_left--;
			end else begin
				case (rx_mode)
					RX_OPEN:     rdy = 1'b1;
					RX_PERIODIC: rdy = (rx_cycle % 4) != 0;
					RX_COIN:     rdy = $urandom_range(0, 1);
					default:     rdy = ($urandom_range(0, 4) == 0);
				endcase
			end
		end
		res.ready <= rdy;
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n === 1'b1 && res.valid && res.ready) begin
			if (vis_expected.size() == 0) begin
				report_mismatch("result with no box outstanding", 1'bx, res.visible);
			end else begin
				want = vis_expected.pop_front();
				if (res.visible !== want)
					report_mismatch("visible", want, res.visible);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((box.valid && box.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		box.valid = 1'b0;
		box.min_x = '0;
		box.min_y = '0;
		box.min_z = '0;
		box.max_x = '0;
		box.max_y = '0;
		box.max_z = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;
		// Identity after reset.
		vp_regs[REG_ROW1_LO] = 64'h0000_0000_0001_0000;
		vp_regs[REG_ROW1_HI] = 64'h0;
		vp_regs[REG_ROW2_LO] = 64'h0001_0000_0000_0000;
		vp_regs[REG_ROW2_HI] = 64'h0;
		vp_regs[REG_ROW3_LO] = 64'h0;
		vp_regs[REG_ROW3_HI] = 64'h0000_0000_0001_0000;
		vp_regs[REG_ROW4_LO] = 64'h0;
		vp_regs[REG_ROW4_HI] = 64'h0001_0000_0000_0000;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With the identity matrix the frustum is |x| < 1, |y| < 1, 0 < z < 1.
		box_pending.push_back(mk_box(-32'sh8000, -32'sh8000, 32'sh4000,
			32'sh8000, 32'sh8000, 32'shC000));
		box_pending.push_back(mk_box(-32'sh8000, -32'sh8000, -ONE, 32'sh8000, 32'sh8000, 0));
		box_pending.push_back(mk_box(-32'sh8000, -32'sh8000, -ONE, 32'sh8000, 32'sh8000, 1));
		box_pending.push_back(mk_box(-3*ONE, 0, 32'sh8000, -2*ONE, 0, 32'sh8000));
		box_pending.push_back(mk_box(2*ONE, 0, 32'sh8000, 3*ONE, 0, 32'sh8000));
		box_pending.push_back(mk_box(0, 2*ONE, 32'sh8000, 0, 3*ONE, 32'sh8000));
		box_pending.push_back(mk_box(0, -3*ONE, 32'sh8000, 0, -2*ONE, 32'sh8000));
		box_pending.push_back(mk_box(0, 0, 2*ONE, 0, 0, 3*ONE));
		box_pending.push_back(mk_box(0, 0, ONE, 0, 0, 2*ONE));
		box_pending.push_back(mk_box(0, 0, ONE - 1, 0, 0, 2*ONE));
		// Minimum above maximum on every axis.
		box_pending.push_back(mk_box(32'sh8000, 32'sh8000, 32'shC000,
			-32'sh8000, -32'sh8000, 32'sh4000));
		box_pending.push_back(mk_box(0, 0, 32'sh8000, 0, 0, 32'sh8000));
		box_pending.push_back(mk_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		box_pending.push_back(mk_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		box_pending.push_back(mk_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		box_pending.push_back(mk_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		box_pending.push_back(mk_box(-1, -1, -1, 1, 1, 1));
		box_pending.push_back(mk_box(-2*ONE, 0, 32'sh8000, -ONE, 0, 32'sh8000));
		box_pending.push_back(mk_box(-2*ONE, 0, 32'sh8000, -ONE + 1, 0, 32'sh8000));
		box_pending.push_back(mk_box(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
			32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555));
		repeat (200)
			box_pending.push_back(random_box(90));
		wait_drained();

		run_phase(MAT_SMALL,   250, 90, 1'b1);
		run_phase(MAT_EXTREME,  60, 30, 1'b0);
		run_phase(MAT_SMALL,   250, 90, 1'b0);
		run_phase(MAT_ZERO,     20, 50, 1'b0);
		run_phase(MAT_RANDOM,  150,  0, 1'b0);
		run_phase(MAT_DONLY,    20, 50, 1'b0);
		run_phase(MAT_SMALL,   250, 90, 1'b0);
		run_phase(MAT_ONES,     30, 50, 1'b0);
		run_phase(MAT_EXTREME,  60, 30, 1'b0);
		run_phase(MAT_RANDOM,  150,  0, 1'b0);
		run_phase(MAT_SMALL,   250, 90, 1'b0);
		run_phase(MAT_RANDOM,  150,  0, 1'b0);

		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
